// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL modules, included by crc_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CRC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CRC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/crc_pkg.sv =====
`default_nettype none
package crc_pkg;

   // Event codes carried by the mode field
   typedef enum logic [2:0] {
      MODE_STAT_RD = 3'd0,
      MODE_CTRL_WR = 3'd1,
      MODE_DATA_RD = 3'd2,
      MODE_DATA_WR = 3'd3,
      MODE_TICK    = 3'd4,
      MODE_ATTACH  = 3'd5,
      MODE_DETACH  = 3'd6
   } mode_type;

   // Card pick outcomes
   typedef enum logic [1:0] {
      PICK_OK    = 2'd0,
      PICK_EOF   = 2'd1,
      PICK_EMPTY = 2'd2,
      PICK_FAULT = 2'd3
   } pick_type;

   localparam int unsigned WORD_W = 18;
   localparam int unsigned COL_W  = 12;
   localparam int unsigned IDX_W  = 7;
   localparam logic [IDX_W-1:0] CARD_COLUMNS = 7'd80;

   // Status word bits
   localparam logic [WORD_W-1:0] ST_PIA       = 18'o0000007;
   localparam logic [WORD_W-1:0] ST_DATA_RDY  = 18'o0000010;
   localparam logic [WORD_W-1:0] ST_END_CARD  = 18'o0000020;
   localparam logic [WORD_W-1:0] ST_END_FILE  = 18'o0000040;
   localparam logic [WORD_W-1:0] ST_RDY_READ  = 18'o0000100;
   localparam logic [WORD_W-1:0] ST_DATA_MISS = 18'o0000200;
   localparam logic [WORD_W-1:0] ST_TROUBLE   = 18'o0000400;
   localparam logic [WORD_W-1:0] ST_READING   = 18'o0001000;
   localparam logic [WORD_W-1:0] ST_HOPPER_MT = 18'o0002000;
   localparam logic [WORD_W-1:0] ST_CARD_IN   = 18'o0004000;
   localparam logic [WORD_W-1:0] ST_STOP      = 18'o0010000;
   localparam logic [WORD_W-1:0] ST_CELL      = 18'o0040000;
   localparam logic [WORD_W-1:0] ST_PICK      = 18'o0100000;
   localparam logic [WORD_W-1:0] ST_RDY_EN    = 18'o0200000;
   localparam logic [WORD_W-1:0] ST_TRB_EN    = 18'o0400000;

   // Control word bits
   localparam logic [WORD_W-1:0] CW_CLEARS   = 18'o0000270;
   localparam logic [WORD_W-1:0] CW_EN_READY = 18'o0000100;
   localparam logic [WORD_W-1:0] CW_EN_TRB   = 18'o0000400;
   localparam logic [WORD_W-1:0] CW_READ     = 18'o0001000;
   localparam logic [WORD_W-1:0] CW_RESET    = 18'o0010000;

   // One event as held in the input register
   typedef struct packed {
      mode_type          mode;
      logic [WORD_W-1:0] control_word;
      logic              attached;
      logic              card_ready;
      pick_type          pick_result;
      logic [COL_W-1:0]  column_value;
   } item_type;

   // One result as held in the result register
   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic              irq_clear;
      logic              irq_set;
      logic [2:0]        irq_level;
   } result_type;

endpackage
`default_nettype wire

// ===== hw/rtl/card_reader_controller_unit.sv =====
// Card reader controller: each accepted item is one register access or reader
// event, and each gives exactly one result. An item is registered on entry, its
// state update and result are worked out in the following cycle and caught in a
// result register when that register has room, so a full and stalled result
// register holds the item in the input register, and one item can be accepted
// every cycle while req_stall is low. req_stall rises only while an item waits in
// the input register and the result register is full and stalled.
`default_nettype none
module card_reader_controller_unit
   import crc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_mode,
   input  wire logic [WORD_W-1:0] req_control_word,
   input  wire logic              req_attached,
   input  wire logic              req_card_ready,
   input  wire logic [1:0]        req_pick_result,
   input  wire logic [COL_W-1:0]  req_column_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [WORD_W-1:0]      rsp_read_data,
   output logic                   rsp_irq_clear,
   output logic                   rsp_irq_set,
   output logic [2:0]             rsp_irq_level
);

   item_type   req_item, item;
   result_type result, rsp_result;
   logic       item_valid, space, fire;

   // Gather the input fields into one item
   always_comb begin
      req_item.mode         = mode_type'(req_mode);
      req_item.control_word = req_control_word;
      req_item.attached     = req_attached;
      req_item.card_ready   = req_card_ready;
      req_item.pick_result  = pick_type'(req_pick_result);
      req_item.column_value = req_column_value;
   end

   // Move the held item on when the result register has room
   assign fire      = item_valid && space;
   assign req_stall = item_valid && !space;

   crc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item)
   );

   crc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   crc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .space      (space),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_read_data = rsp_result.read_data;
   assign rsp_irq_clear = rsp_result.irq_clear;
   assign rsp_irq_set   = rsp_result.irq_set;
   assign rsp_irq_level = rsp_result.irq_level;

endmodule
`default_nettype wire

// ===== hw/rtl/crc_in_stage.sv =====
`default_nettype none
module crc_in_stage
   import crc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_stall,
   input  wire item_type req_item,
   output logic          item_valid,
   output item_type      item
);

   logic     vld_ff, vld_in;
   item_type item_ff;

   // Load a new item unless stalled, otherwise hold
   assign vld_in = req_stall ? vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/crc_engine.sv =====
`default_nettype none
`include "assert_macros.svh"
module crc_engine
   import crc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     fire,
   input  wire item_type item,
   output result_type    result
);

   logic [WORD_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]  col_idx_ff, col_idx_in;
   logic [COL_W-1:0]  hold_ff, hold_in;

   // Work out the next state and the result for the held item
   always_comb begin
      logic [WORD_W-1:0] s;
      logic [WORD_W-1:0] cw;
      logic [WORD_W-1:0] rd;
      logic              clr;
      logic              set;
      s          = status_ff;
      cw         = item.control_word;
      rd         = '0;
      clr        = 1'b0;
      set        = 1'b0;
      col_idx_in = col_idx_ff;
      hold_in    = hold_ff;
      case (item.mode)
         MODE_STAT_RD: begin
            if (item.attached && item.card_ready &&
                (s & (ST_TROUBLE | ST_READING | ST_CARD_IN | ST_END_CARD)) == '0) begin
               s = s | ST_RDY_READ;
            end
            rd = s;
         end
         MODE_CTRL_WR: begin
            clr = 1'b1;
            if ((cw & CW_RESET) != '0) begin
               s = item.card_ready ? '0 : ST_END_FILE;
            end else begin
               s = (s & ~ST_PIA) | (cw & ST_PIA);
               s = s & ~(cw & CW_CLEARS);
               if ((cw & CW_EN_TRB) != '0) s = s | ST_TRB_EN;
               if ((cw & CW_EN_READY) != '0) s = s | ST_RDY_EN;
               if (item.attached && (cw & CW_READ) != '0) begin
                  s = s | ST_READING;
                  s = s & ~(ST_CARD_IN | ST_RDY_READ | ST_DATA_RDY);
                  col_idx_in = '0;
               end else begin
                  s = s | (item.card_ready ? ST_RDY_READ : ST_STOP);
                  set = ((s & ST_RDY_EN) != '0 && (s & ST_RDY_READ) != '0) ||
                        ((s & ST_TRB_EN) != '0 && (s & ST_TROUBLE) != '0);
               end
            end
         end
         MODE_DATA_RD: begin
            clr = 1'b1;
            if ((s & ST_DATA_RDY) != '0) begin
               rd = {{(WORD_W-COL_W){1'b0}}, hold_ff};
               s  = s & ~ST_DATA_RDY;
            end
         end
         MODE_TICK: begin
            if (item.attached && item.card_ready &&
                (s & (ST_READING | ST_CARD_IN | ST_RDY_READ)) == '0) begin
               // report a card ready to read
               s   = s | ST_RDY_READ;
               set = (s & ST_RDY_EN) != '0;
            end else if ((s & (ST_READING | ST_CARD_IN)) == ST_READING) begin
               // pick a card
               s = s & ~(ST_END_CARD | ST_RDY_READ);
               if (item.pick_result == PICK_OK) begin
                  s = s | ST_CARD_IN;
                  col_idx_in = '0;
               end else begin
                  s = s & ~(ST_CARD_IN | ST_READING);
                  if (item.pick_result == PICK_EOF) begin
                     s   = s | ST_END_FILE;
                     set = 1'b1;
                  end else begin
                     s = s | ST_TROUBLE | ST_STOP |
                         ((item.pick_result == PICK_EMPTY) ? ST_HOPPER_MT : ST_PICK);
                     set = (s & ST_TRB_EN) != '0;
                  end
               end
            end else if ((s & ST_CARD_IN) != '0) begin
               if (col_idx_ff >= CARD_COLUMNS) begin
                  // past the last column: end of card
                  s   = (s & ~(ST_CARD_IN | ST_READING)) | ST_END_CARD;
                  set = 1'b1;
               end else begin
                  // move one column, flag overrun
                  hold_in    = item.column_value;
                  col_idx_in = col_idx_ff + IDX_W'(1);
                  if ((s & ST_DATA_RDY) != '0) s = s | ST_DATA_MISS;
                  s   = s | ST_DATA_RDY;
                  set = 1'b1;
               end
            end
         end
         MODE_ATTACH: begin
            if ((s & (ST_READING | ST_CARD_IN)) == '0) begin
               s   = s | ST_RDY_READ;
               s   = s & ~(ST_HOPPER_MT | ST_STOP | ST_TROUBLE | ST_CELL | ST_PICK);
               set = (s & ST_RDY_EN) != '0;
            end
         end
         MODE_DETACH: begin
            if (item.attached) begin
               s   = s | ST_TROUBLE | ST_HOPPER_MT;
               set = (s & ST_TRB_EN) != '0;
            end
            s = s & ~ST_RDY_READ;
         end
         default: begin
            // data write and the unused code leave everything alone
         end
      endcase
      status_in        = s;
      result.read_data = rd;
      result.irq_clear = clr;
      result.irq_set   = set;
      result.irq_level = s[2:0];
   end

   // Advance the controller state only when the item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= '0;
         col_idx_ff <= '0;
         hold_ff    <= '0;
      end else if (fire) begin
         status_ff  <= status_in;
         col_idx_ff <= col_idx_in;
         hold_ff    <= hold_in;
      end
   end

   `CRC_ASSERT_IMP(a_col_bound, clock, reset, 1'b1, col_idx_ff <= CARD_COLUMNS, "column index past end of card")
   `CRC_ASSERT_NXT(a_wr_quiet, clock, reset, fire && item.mode == MODE_DATA_WR, $stable(status_ff) && $stable(hold_ff), "data write changed state")
   `CRC_ASSERT_NXT(a_rd_clears, clock, reset, fire && item.mode == MODE_DATA_RD, (status_ff & ST_DATA_RDY) == '0, "data ready left set after data read")

endmodule
`default_nettype wire

// ===== hw/rtl/crc_out_stage.sv =====
`default_nettype none
module crc_out_stage
   import crc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire result_type result,
   input  wire logic       rsp_stall,
   output logic            space,
   output logic            rsp_valid,
   output result_type      rsp_result
);

   logic       vld_ff, vld_in;
   result_type res_ff;

   // Take a new result when empty or when the current one is taken
   assign space  = !vld_ff || !rsp_stall;
   assign vld_in = space ? fire : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= result;
      end
   end

   assign rsp_valid  = vld_ff;
   assign rsp_result = res_ff;

endmodule
`default_nettype wire

// ===== tb/card_reader_tb_pkg.sv =====
`default_nettype none
package card_reader_tb_pkg;
   import crc_pkg::*;

   // Mode code outside the defined set: the block must treat it as a no-op
   localparam logic [2:0] MODE_SPARE = 3'd7;
   localparam int unsigned REPORT_LIMIT = 10;

   // One event as the driver presents it; mode and pick stay raw so that
   // the unused mode code can be sent as well
   typedef struct packed {
      logic [2:0]        mode;
      logic [WORD_W-1:0] control_word;
      logic              attached;
      logic              card_ready;
      logic [1:0]        pick;
      logic [COL_W-1:0]  column_value;
   } card_event_type;

   // Shadow of the controller registers plus the queue of results still owed
   class card_reader_scoreboard;
      logic [WORD_W-1:0] status_q;
      logic [IDX_W-1:0]  col_idx;
      logic [COL_W-1:0]  col_hold;
      result_type        pending_results[$];
      int unsigned       fail_count;

      function new();
         status_q   = '0;
         col_idx    = '0;
         col_hold   = '0;
         fail_count = 0;
      endfunction

      // Work out the result of one accepted item and advance the shadow state
      function void log_event(input card_event_type ev);
         logic [WORD_W-1:0] s;
         logic [WORD_W-1:0] cw;
         result_type        r;
         s  = status_q;
         cw = ev.control_word;
         r  = '0;
         case (ev.mode)
            MODE_STAT_RD: begin
               if (ev.attached && ev.card_ready &&
                   (s & (ST_TROUBLE | ST_READING | ST_CARD_IN | ST_END_CARD)) == '0)
                  s |= ST_RDY_READ;
               r.read_data = s;
            end
            MODE_CTRL_WR: begin
               r.irq_clear = 1'b1;
               if ((cw & CW_RESET) != '0) begin
                  // reader reset wipes the status, leaving end of file if no card
                  s = ev.card_ready ? '0 : ST_END_FILE;
               end else begin
                  s = (s & ~ST_PIA) | (cw & ST_PIA);
                  s &= ~(cw & CW_CLEARS);
                  if ((cw & CW_EN_TRB) != '0) s |= ST_TRB_EN;
                  if ((cw & CW_EN_READY) != '0) s |= ST_RDY_EN;
                  if (ev.attached && (cw & CW_READ) != '0) begin
                     s |= ST_READING;
                     s &= ~(ST_CARD_IN | ST_RDY_READ | ST_DATA_RDY);
                     col_idx = '0;
                  end else begin
                     if (ev.card_ready) s |= ST_RDY_READ;
                     else s |= ST_STOP;
                     if ((s & ST_RDY_EN) != '0 && (s & ST_RDY_READ) != '0)
                        r.irq_set = 1'b1;
                     if ((s & ST_TRB_EN) != '0 && (s & ST_TROUBLE) != '0)
                        r.irq_set = 1'b1;
                  end
               end
            end
            MODE_DATA_RD: begin
               r.irq_clear = 1'b1;
               if ((s & ST_DATA_RDY) != '0) begin
                  r.read_data = {{(WORD_W-COL_W){1'b0}}, col_hold};
                  s &= ~ST_DATA_RDY;
               end
            end
            MODE_TICK: begin
               if (ev.attached && ev.card_ready &&
                   (s & (ST_READING | ST_CARD_IN | ST_RDY_READ)) == '0) begin
                  // report a card waiting in the hopper
                  s |= ST_RDY_READ;
                  r.irq_set = ((s & ST_RDY_EN) != '0);
               end else if ((s & (ST_READING | ST_CARD_IN)) == ST_READING) begin
                  // pick a card
                  s &= ~(ST_END_CARD | ST_RDY_READ);
                  if (ev.pick == PICK_OK) begin
                     s |= ST_CARD_IN;
                     col_idx = '0;
                  end else begin
                     s &= ~(ST_CARD_IN | ST_READING);
                     if (ev.pick == PICK_EOF) begin
                        s |= ST_END_FILE;
                        r.irq_set = 1'b1;
                     end else begin
                        s |= ST_TROUBLE | ST_STOP |
                             ((ev.pick == PICK_EMPTY) ? ST_HOPPER_MT : ST_PICK);
                        r.irq_set = ((s & ST_TRB_EN) != '0);
                     end
                  end
               end else if ((s & ST_CARD_IN) != '0) begin
                  if (col_idx >= CARD_COLUMNS) begin
                     // all columns moved: close the card
                     s &= ~(ST_CARD_IN | ST_READING);
                     s |= ST_END_CARD;
                  end else begin
                     col_hold = ev.column_value;
                     col_idx  = col_idx + IDX_W'(1);
                     if ((s & ST_DATA_RDY) != '0) s |= ST_DATA_MISS;
                     s |= ST_DATA_RDY;
                  end
                  r.irq_set = 1'b1;
               end
            end
            MODE_ATTACH: begin
               if ((s & (ST_READING | ST_CARD_IN)) == '0) begin
                  s |= ST_RDY_READ;
                  s &= ~(ST_HOPPER_MT | ST_STOP | ST_TROUBLE | ST_CELL | ST_PICK);
                  r.irq_set = ((s & ST_RDY_EN) != '0);
               end
            end
            MODE_DETACH: begin
               if (ev.attached) begin
                  s |= ST_TROUBLE | ST_HOPPER_MT;
                  r.irq_set = ((s & ST_TRB_EN) != '0);
               end
               s &= ~ST_RDY_READ;
            end
            default: begin
            end
         endcase
         status_q    = s;
         r.irq_level = s[2:0];
         pending_results.push_back(r);
      endfunction

      // Compare one delivered result with the oldest one owed
      function void check_result(input result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected result: rd=%o clr=%0d set=%0d lvl=%0d",
                        got.read_data, got.irq_clear, got.irq_set, got.irq_level);
            return;
         end
         want = pending_results.pop_front();
         if (got.read_data !== want.read_data || got.irq_clear !== want.irq_clear ||
             got.irq_set !== want.irq_set || got.irq_level !== want.irq_level) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display({"result mismatch: want rd=%o clr=%0d set=%0d lvl=%0d,",
                         " got rd=%o clr=%0d set=%0d lvl=%0d"},
                        want.read_data, want.irq_clear, want.irq_set, want.irq_level,
                        got.read_data, got.irq_clear, got.irq_set, got.irq_level);
         end
      endfunction
   endclass

endpackage
`default_nettype wire

// ===== tb/tb_card_reader_controller_unit.sv =====
`default_nettype none
module tb_card_reader_controller_unit;
   import crc_pkg::*;
   import card_reader_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned EVENT_TARGET = 900;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned IDLE_PCT     = 22;
   // control bits a card read may carry besides the read request itself
   localparam logic [WORD_W-1:0] CARD_CW_MASK =
      ST_PIA | CW_CLEARS | CW_EN_READY | CW_EN_TRB | 18'o0004000;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [2:0]        req_mode         = '0;
   logic [WORD_W-1:0] req_control_word = '0;
   logic              req_attached     = 1'b0;
   logic              req_card_ready   = 1'b0;
   logic [1:0]        req_pick_result  = '0;
   logic [COL_W-1:0]  req_column_value = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [WORD_W-1:0] rsp_read_data;
   logic              rsp_irq_clear;
   logic              rsp_irq_set;
   logic [2:0]        rsp_irq_level;

   int unsigned events_sent = 0;
   int unsigned cycle_count = 0;
   logic        quiet;

   card_reader_scoreboard tracker = new();

   // Run a stretch in the middle with no idling on either side
   assign quiet = (events_sent >= 350) && (events_sent < 550);

   always #4 clock = ~clock;

   card_reader_controller_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_control_word (req_control_word),
      .req_attached     (req_attached),
      .req_card_ready   (req_card_ready),
      .req_pick_result  (req_pick_result),
      .req_column_value (req_column_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_irq_clear    (rsp_irq_clear),
      .rsp_irq_set      (rsp_irq_set),
      .rsp_irq_level    (rsp_irq_level)
   );

   function automatic card_event_type make_event(input logic [2:0] mode,
                                                 input logic [WORD_W-1:0] cw,
                                                 input logic att,
                                                 input logic rdy,
                                                 input logic [1:0] pick,
                                                 input logic [COL_W-1:0] colv);
      card_event_type ev;
      ev.mode         = mode;
      ev.control_word = cw;
      ev.attached     = att;
      ev.card_ready   = rdy;
      ev.pick         = pick;
      ev.column_value = colv;
      return ev;
   endfunction

   // Fully random event, now and then with the unused mode code
   function automatic card_event_type random_event();
      logic [2:0] mode;
      mode = ($urandom_range(99) < 3) ? MODE_SPARE : 3'($urandom_range(6));
      return make_event(mode, WORD_W'($urandom()), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 2'($urandom_range(3)), COL_W'($urandom()));
   endfunction

   // Present one item, idling at random first, and hold it until accepted
   task automatic send_event(input card_event_type ev);
      while ($urandom_range(99) < (quiet ? 0 : IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= ev.mode;
      req_control_word <= ev.control_word;
      req_attached     <= ev.attached;
      req_card_ready   <= ev.card_ready;
      req_pick_result  <= ev.pick;
      req_column_value <= ev.column_value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.log_event(ev);
      events_sent++;
   endtask

   // Read one card: maybe attach, read status, start, pick, then on a good pick move every column and close
   task automatic read_one_card();
      logic [1:0]  pick;
      int unsigned roll;
      if ($urandom_range(1))
         send_event(make_event(MODE_ATTACH, WORD_W'($urandom()), 1'b1, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_STAT_RD, '0, 1'b1, 1'($urandom_range(1)), PICK_OK, '0));
      send_event(make_event(MODE_CTRL_WR, (WORD_W'($urandom()) & CARD_CW_MASK) | CW_READ,
                            1'b1, 1'($urandom_range(1)), PICK_OK, '0));
      pick = ($urandom_range(99) < 80) ? 2'(PICK_OK) : 2'($urandom_range(1, 3));
      send_event(make_event(MODE_TICK, WORD_W'($urandom()), $urandom_range(99) < 90,
                            1'($urandom_range(1)), pick, COL_W'($urandom())));
      if (pick != PICK_OK) return;
      repeat (CARD_COLUMNS + 1) begin
         send_event(make_event(MODE_TICK, WORD_W'($urandom()), 1'b1,
                               1'($urandom_range(1)), 2'($urandom_range(3)),
                               COL_W'($urandom())));
         roll = $urandom_range(99);
         // mostly drain each column; skip now and then to force an overrun
         if (roll < 80)
            send_event(make_event(MODE_DATA_RD, WORD_W'($urandom()),
                                  1'($urandom_range(1)), 1'($urandom_range(1)),
                                  PICK_OK, '0));
         else if (roll < 88)
            send_event(make_event(MODE_STAT_RD, '0, 1'($urandom_range(1)),
                                  1'($urandom_range(1)), PICK_OK, '0));
         else if (roll < 91)
            send_event(random_event());
      end
   endtask

   // Stall the result side at random and check every delivered result
   always @(posedge clock) begin
      rsp_stall <= !reset && !quiet && ($urandom_range(99) < IDLE_PCT);
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(result_type'{rsp_read_data, rsp_irq_clear, rsp_irq_set,
                                           rsp_irq_level});
   end

   // Give up if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("card_reader_controller_unit verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned roll;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every mode and the odd cases
      send_event(make_event(MODE_STAT_RD, '0, 1'b1, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_CTRL_WR, 18'o777777, 1'b1, 1'b1, PICK_FAULT, 12'o7777));
      send_event(make_event(MODE_CTRL_WR, CW_RESET, 1'b0, 1'b0, PICK_OK, '0));
      send_event(make_event(MODE_CTRL_WR, ST_PIA | CW_EN_READY | CW_EN_TRB, 1'b1, 1'b1,
                            PICK_OK, '0));
      send_event(make_event(MODE_CTRL_WR, '0, 1'b0, 1'b0, PICK_OK, '0));
      send_event(make_event(MODE_DATA_RD, '0, 1'b1, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_DATA_WR, 18'o777777, 1'b1, 1'b1, PICK_FAULT, 12'o7777));
      send_event(make_event(MODE_SPARE, 18'o777777, 1'b1, 1'b1, PICK_FAULT, 12'o7777));
      send_event(make_event(MODE_TICK, '0, 1'b0, 1'b0, PICK_OK, '0));
      send_event(make_event(MODE_DETACH, '0, 1'b0, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_CTRL_WR, CW_EN_TRB, 1'b1, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_DETACH, '0, 1'b1, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_ATTACH, '0, 1'b0, 1'b0, PICK_OK, '0));
      send_event(make_event(MODE_CTRL_WR, CW_READ, 1'b0, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_CTRL_WR, 18'o0004005 | CW_READ, 1'b1, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_TICK, '0, 1'b0, 1'b0, PICK_EOF, '0));
      send_event(make_event(MODE_CTRL_WR, CW_READ, 1'b1, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_TICK, '0, 1'b1, 1'b1, PICK_EMPTY, '0));
      send_event(make_event(MODE_ATTACH, '0, 1'b1, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_CTRL_WR, CW_READ | CW_CLEARS, 1'b1, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_TICK, '0, 1'b1, 1'b1, PICK_FAULT, '0));
      send_event(make_event(MODE_ATTACH, '0, 1'b1, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_CTRL_WR, CW_READ | CW_EN_READY, 1'b1, 1'b0, PICK_OK, '0));
      send_event(make_event(MODE_TICK, '0, 1'b1, 1'b1, PICK_OK, '0));
      send_event(make_event(MODE_TICK, '0, 1'b1, 1'b1, PICK_OK, 12'o7777));
      send_event(make_event(MODE_TICK, '0, 1'b1, 1'b0, PICK_OK, '0));
      send_event(make_event(MODE_DATA_RD, '0, 1'b1, 1'b1, PICK_OK, '0));

      // Random: mostly whole card reads, with control traffic and noise between
      while (events_sent < EVENT_TARGET) begin
         roll = $urandom_range(99);
         if (roll < 45)
            read_one_card();
         else if (roll < 65)
            send_event(make_event(MODE_CTRL_WR, WORD_W'($urandom()) & ~CW_RESET,
                                  1'($urandom_range(1)), 1'($urandom_range(1)),
                                  PICK_OK, '0));
         else if (roll < 75)
            send_event(make_event(MODE_STAT_RD, '0, 1'($urandom_range(1)),
                                  1'($urandom_range(1)), PICK_OK, '0));
         else if (roll < 82)
            send_event(make_event($urandom_range(1) ? MODE_ATTACH : MODE_DETACH, '0,
                                  1'($urandom_range(1)), 1'($urandom_range(1)),
                                  PICK_OK, '0));
         else
            send_event(random_event());
      end
      req_valid <= 1'b0;

      // Drain the results still owed, then let the pipeline settle
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.fail_count == 0)
         $display("card_reader_controller_unit verification clean");
      else
         $display("card_reader_controller_unit verification failed");
      $finish;
   end

endmodule
`default_nettype wire
